[rtl/skt_pkg.sv]
package skt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned GradeW = 8;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 6;
  localparam int unsigned CapW   = 6;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                     cmp_en;
    logic                     ins;
    logic                     del;
    logic signed [KeyW-1:0]   key;
    logic [GradeW-1:0]        grade;
  } cell_ctrl_t;

endpackage

[rtl/skt_in_if.sv]
interface skt_in_if
  import skt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic signed [KeyW-1:0] key;
  logic [GradeW-1:0]      grade_in;

  modport source (output valid, output operation, output key, output grade_in, input ready);
  modport sink (input valid, input operation, input key, input grade_in, output ready);
endinterface

[rtl/skt_out_if.sv]
interface skt_out_if
  import skt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PosW-1:0]   position;
  logic [GradeW-1:0] grade_out;
  logic [CountW-1:0] entry_count;

  modport source (output valid, output status, output position, output grade_out,
                  output entry_count, input ready);
  modport sink (input valid, input status, input position, input grade_out,
                input entry_count, output ready);
endinterface

[rtl/skt_cfg_if.sv]
interface skt_cfg_if
  import skt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/sorted_key_table_unit.sv]
// Channel | Dir | Transaction payload
// in_i    | in  | operation, key, grade_in
// out_o   | out | status, position, grade_out, entry_count
// cfg_i   | in  | capacity_limit (always ready)
// On accept, each cell of the chain registers its key compare, and at commit the chain
// shifts and the result is loaded.
// Reset empties the table and sets capacity_limit to 32.
// A result waiting on out_o holds back the next commit, and in_i is ready only
// while no operation is in progress.
module sorted_key_table_unit
  import skt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  skt_in_if.sink  in_i,
  skt_out_if.source out_o,
  skt_cfg_if.sink cfg_i
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LimW = (CntW > CapW) ? CntW : CapW;

  fsm_e                   state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CapW-1:0]        cap_q;
  logic [1:0]             op_q;
  logic signed [KeyW-1:0] key_q;
  logic [GradeW-1:0]      grade_q;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [GradeW-1:0] gout_q, gout_d;
  logic [CountW-1:0] ecnt_q, ecnt_d;

  cell_ctrl_t ctrl;

  logic signed [KeyW-1:0] cell_key   [TABLE_DEPTH];
  logic [GradeW-1:0]      cell_grade [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_valid, cell_lt, cell_eq, boundary;

  logic              accept, commit, found, full;
  logic [IdxW-1:0]   ins_pos, hit_pos;
  logic [GradeW-1:0] hit_grade;
  logic [LimW-1:0]   limit;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                   left_lt, left_valid, right_valid;
    logic signed [KeyW-1:0] left_key, right_key;
    logic [GradeW-1:0]      left_grade, right_grade;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_key   = ctrl.key;
      assign left_grade = ctrl.grade;
      assign left_valid = 1'b0;
    end else begin : g_mid
      assign left_lt    = cell_lt[i-1];
      assign left_key   = cell_key[i-1];
      assign left_grade = cell_grade[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_key   = ctrl.key;
      assign right_grade = ctrl.grade;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_key   = cell_key[i+1];
      assign right_grade = cell_grade[i+1];
      assign right_valid = cell_valid[i+1];
    end

    assign boundary[i] = !cell_lt[i] && left_lt;

    skt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_lt_i     (left_lt),
      .left_key_i    (left_key),
      .left_grade_i  (left_grade),
      .left_valid_i  (left_valid),
      .right_key_i   (right_key),
      .right_grade_i (right_grade),
      .right_valid_i (right_valid),
      .key_o         (cell_key[i]),
      .grade_o       (cell_grade[i]),
      .valid_o       (cell_valid[i]),
      .lt_o          (cell_lt[i]),
      .eq_o          (cell_eq[i])
    );
  end

  always_comb begin
    ins_pos   = '0;
    hit_pos   = '0;
    hit_grade = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (boundary[i]) begin
        ins_pos = ins_pos | IdxW'(i);
      end
      if (cell_eq[i]) begin
        hit_pos   = hit_pos | IdxW'(i);
        hit_grade = hit_grade | cell_grade[i];
      end
    end
  end

  assign found = |cell_eq;
  assign limit = (LimW'(cap_q) < LimW'(TABLE_DEPTH)) ? LimW'(cap_q) : LimW'(TABLE_DEPTH);
  assign full  = LimW'(count_q) >= limit;

  assign accept = in_i.valid && in_i.ready;
  assign commit = (state_q == FSM_EXEC) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    pos_d       = pos_q;
    gout_d      = gout_q;
    ecnt_d      = ecnt_q;
    ctrl.cmp_en = accept;
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.key    = accept ? in_i.key : key_q;
    ctrl.grade  = grade_q;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (commit) begin
          state_d     = FSM_IDLE;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          pos_d       = '0;
          gout_d      = '0;
          case (op_q)
            OP_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (found) begin
                status_d = ST_DUP;
              end else begin
                ctrl.ins = 1'b1;
                pos_d    = PosW'(ins_pos);
                count_d  = count_q + CntW'(1);
              end
            end
            OP_DELETE: begin
              if (!found) begin
                status_d = ST_MISSING;
              end else begin
                ctrl.del = 1'b1;
                count_d  = count_q - CntW'(1);
              end
            end
            default: begin
              if (!found) begin
                status_d = ST_MISSING;
              end else begin
                pos_d  = PosW'(hit_pos);
                gout_d = hit_grade;
              end
            end
          endcase
          ecnt_d = CountW'(count_d);
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      cap_q       <= CapW'(32);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.operation;
      key_q   <= in_i.key;
      grade_q <= in_i.grade_in;
    end
    status_q <= status_d;
    pos_q    <= pos_d;
    gout_q   <= gout_d;
    ecnt_q   <= ecnt_d;
  end

  assign in_i.ready        = (state_q == FSM_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.position    = pos_q;
  assign out_o.grade_out   = gout_q;
  assign out_o.entry_count = ecnt_q;

endmodule

[rtl/skt_cell.sv]
module skt_cell
  import skt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  input  logic                   left_lt_i,
  input  logic signed [KeyW-1:0] left_key_i,
  input  logic [GradeW-1:0]      left_grade_i,
  input  logic                   left_valid_i,
  input  logic signed [KeyW-1:0] right_key_i,
  input  logic [GradeW-1:0]      right_grade_i,
  input  logic                   right_valid_i,
  output logic signed [KeyW-1:0] key_o,
  output logic [GradeW-1:0]      grade_o,
  output logic                   valid_o,
  output logic                   lt_o,
  output logic                   eq_o
);

  logic signed [KeyW-1:0] key_q, key_d;
  logic [GradeW-1:0]      grade_q, grade_d;
  logic                   valid_q, valid_d;
  logic                   lt_q, eq_q;

  always_comb begin
    key_d   = key_q;
    grade_d = grade_q;
    valid_d = valid_q;
    if (ctrl_i.ins && !lt_q) begin
      if (left_lt_i) begin
        key_d   = ctrl_i.key;
        grade_d = ctrl_i.grade;
        valid_d = 1'b1;
      end else begin
        key_d   = left_key_i;
        grade_d = left_grade_i;
        valid_d = left_valid_i;
      end
    end else if (ctrl_i.del && !lt_q) begin
      key_d   = right_key_i;
      grade_d = right_grade_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        lt_q <= valid_q && (key_q < ctrl_i.key);
        eq_q <= valid_q && (key_q == ctrl_i.key);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    grade_q <= grade_d;
  end

  assign key_o   = key_q;
  assign grade_o = grade_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

[verif/tb.sv]
module tb
  import skt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 32;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic signed [KeyW-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int unsigned POOL_SIZE = 44;

  typedef struct packed {
    logic [1:0]             op;
    logic signed [KeyW-1:0] key;
    logic [GradeW-1:0]      grade;
  } table_op_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PosW-1:0]   position;
    logic [GradeW-1:0] grade_out;
    logic [CountW-1:0] entry_count;
  } table_reply_t;

  logic clk;
  logic rst_n;

  skt_in_if  in_if();
  skt_out_if out_if();
  skt_cfg_if cfg_if();

  sorted_key_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];

  logic signed [KeyW-1:0] tbl_key[DEPTH];
  logic [GradeW-1:0]      tbl_grade[DEPTH];
  int                     tbl_count;
  int                     cap_limit;

  logic signed [KeyW-1:0] key_pool[POOL_SIZE];
  int                     src_idle_pct;
  int                     snk_stall_pct;
  int                     mismatches;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Applies one operation to the shadow table and returns the reply it must produce.
  function automatic table_reply_t apply_table_op(table_op_t t);
    table_reply_t r;
    int           lim;
    int           hit;
    int           loc;
    r.status      = ST_OK;
    r.position    = '0;
    r.grade_out   = '0;
    r.entry_count = '0;
    lim = (cap_limit < DEPTH) ? cap_limit : DEPTH;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == t.key) hit = i;
    end
    if (t.op == OP_INSERT) begin
      if (tbl_count >= lim) begin
        r.status = ST_FULL;
      end else if (hit >= 0) begin
        r.status = ST_DUP;
      end else begin
        loc = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (t.key > tbl_key[i]) loc++;
        end
        for (int i = tbl_count; i > loc; i--) begin
          tbl_key[i]   = tbl_key[i-1];
          tbl_grade[i] = tbl_grade[i-1];
        end
        tbl_key[loc]   = t.key;
        tbl_grade[loc] = t.grade;
        tbl_count++;
        r.position = loc[PosW-1:0];
      end
    end else if (t.op == OP_DELETE) begin
      if (hit < 0) begin
        r.status = ST_MISSING;
      end else begin
        for (int i = hit; i + 1 < tbl_count; i++) begin
          tbl_key[i]   = tbl_key[i+1];
          tbl_grade[i] = tbl_grade[i+1];
        end
        tbl_count--;
      end
    end else begin
      if (hit < 0) begin
        r.status = ST_MISSING;
      end else begin
        r.position  = hit[PosW-1:0];
        r.grade_out = tbl_grade[hit];
      end
    end
    r.entry_count = tbl_count[CountW-1:0];
    return r;
  endfunction

  function automatic table_op_t make_random_op();
    table_op_t t;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 45) t.op = OP_INSERT;
    else if (pick < 70) t.op = OP_DELETE;
    else if (pick < 95) t.op = OP_LOOKUP;
    else t.op = OP_SPARE;
    if ($urandom_range(99) < 85) t.key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else t.key = $urandom;
    t.grade = GradeW'($urandom_range(255));
    return t;
  endfunction

  function automatic table_op_t mk(logic [1:0] op, logic signed [KeyW-1:0] key,
                                   logic [GradeW-1:0] grade);
    table_op_t t;
    t.op    = op;
    t.key   = key;
    t.grade = grade;
    return t;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cap_limit = int'(value);
  endtask

  task automatic run_phase(input logic [CapW-1:0] cap, input int src_pct, input int snk_pct,
                           input int n_ops, input bit hold_midway);
    drain();
    write_capacity(cap);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n_ops / 2; i++) pending_ops.push_back(make_random_op());
    if (hold_midway) drain();
    for (int i = n_ops / 2; i < n_ops; i++) pending_ops.push_back(make_random_op());
    drain();
  endtask

  // Driver: offers the head of the pending queue and predicts it once accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_replies.push_back(apply_table_op(pending_ops.pop_front()));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.operation <= pending_ops[0].op;
          in_if.key       <= pending_ops[0].key;
          in_if.grade_in  <= pending_ops[0].grade;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every reply transaction against the oldest prediction.
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_replies.size() == 0) begin
          note_mismatch($sformatf("unexpected reply status=%0d pos=%0d grade=%0d count=%0d",
                                  out_if.status, out_if.position, out_if.grade_out,
                                  out_if.entry_count));
        end else begin
          want = expected_replies.pop_front();
          if (out_if.status !== want.status || out_if.position !== want.position ||
              out_if.grade_out !== want.grade_out || out_if.entry_count !== want.entry_count) begin
            note_mismatch($sformatf(
              "expected status=%0d pos=%0d grade=%0d count=%0d, got %0d %0d %0d %0d",
              want.status, want.position, want.grade_out, want.entry_count,
              out_if.status, out_if.position, out_if.grade_out, out_if.entry_count));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_INSERT;
    in_if.key       = '0;
    in_if.grade_in  = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    tbl_count       = 0;
    cap_limit       = 32;
    mismatches      = 0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_key[i]   = '0;
      tbl_grade[i] = '0;
    end
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MIN + 1;
    key_pool[2] = -1;
    key_pool[3] = 0;
    key_pool[4] = 1;
    key_pool[5] = 100;
    key_pool[6] = KEY_MAX - 1;
    key_pool[7] = KEY_MAX;
    for (int i = 8; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, extremes of key and grade, duplicate, first and last removal.
    pending_ops.push_back(mk(OP_LOOKUP, 0, 8'd0));
    pending_ops.push_back(mk(OP_DELETE, KEY_MAX, 8'd0));
    pending_ops.push_back(mk(OP_INSERT, 0, 8'h5a));
    pending_ops.push_back(mk(OP_INSERT, KEY_MAX, 8'hff));
    pending_ops.push_back(mk(OP_INSERT, KEY_MIN, 8'h00));
    pending_ops.push_back(mk(OP_INSERT, -1, 8'ha5));
    pending_ops.push_back(mk(OP_INSERT, 100, 8'h3c));
    pending_ops.push_back(mk(OP_INSERT, 0, 8'h11));
    pending_ops.push_back(mk(OP_INSERT, KEY_MIN, 8'h22));
    pending_ops.push_back(mk(OP_LOOKUP, KEY_MIN, 8'hff));
    pending_ops.push_back(mk(OP_LOOKUP, KEY_MAX, 8'h00));
    pending_ops.push_back(mk(OP_SPARE, -1, 8'h00));
    pending_ops.push_back(mk(OP_SPARE, 12345, 8'hff));
    pending_ops.push_back(mk(OP_LOOKUP, 100, 8'h00));
    pending_ops.push_back(mk(OP_DELETE, KEY_MAX, 8'hff));
    pending_ops.push_back(mk(OP_DELETE, KEY_MIN, 8'h00));
    pending_ops.push_back(mk(OP_DELETE, 12345, 8'h00));
    pending_ops.push_back(mk(OP_LOOKUP, KEY_MAX, 8'h00));
    pending_ops.push_back(mk(OP_INSERT, KEY_MAX - 1, 8'h80));
    pending_ops.push_back(mk(OP_INSERT, KEY_MIN + 1, 8'h7f));
    pending_ops.push_back(mk(OP_LOOKUP, 0, 8'h00));
    pending_ops.push_back(mk(OP_DELETE, 100, 8'h00));

    run_phase(6'd32, 0, 0, 300, 1'b0);
    run_phase(6'd63, 81, 0, 300, 1'b1);
    run_phase(6'd0, 0, 81, 100, 1'b0);
    run_phase(6'd1, 28, 28, 150, 1'b0);
    run_phase(6'd32, 28, 28, 250, 1'b1);
    run_phase(6'd7, 0, 0, 150, 1'b0);

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
